FILE: rtl/iwt_pkg.sv
// Shared constants, types and command/status structs for the integer-to-words block.
package iwt_pkg;

	localparam int VALUE_W = 31;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int GROUPS  = 4;
	localparam int GRP_W   = 2;
	localparam int CNT_W   = $clog2(VALUE_W);
	localparam int WORD_W  = 5;

	localparam logic [WORD_W-1:0] WORD_ZERO    = 5'd0;
	localparam logic [WORD_W-1:0] WORD_TEN     = 5'd10;
	localparam logic [WORD_W-1:0] WORD_TWENTY  = 5'd20;
	localparam logic [WORD_W-1:0] WORD_HUNDRED = 5'd28;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_SCAN,
		ST_ZERO,
		ST_HDIG,
		ST_HWORD,
		ST_TAIL,
		ST_ONES,
		ST_SCALE
	} state_t;

	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_HDIG,
		SEL_HWORD,
		SEL_TAIL,
		SEL_ONES,
		SEL_SCALE
	} sel_t;

	typedef struct packed {
		logic             load;
		logic             shift;
		logic             emit;
		logic             last;
		sel_t             sel;
		logic [GRP_W-1:0] grp;
	} dp_cmd_t;

	typedef struct packed {
		logic [GROUPS-1:0] grp_nz;
		logic [GROUPS-1:0] hund_nz;
		logic [GROUPS-1:0] tail_nz;
		logic [GROUPS-1:0] pair;
	} dp_stat_t;

endpackage

FILE: rtl/iwt_dp.sv
// Datapath: shift-and-add-3 binary to BCD converter, group flags and word output register.
module iwt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  iwt_pkg::dp_cmd_t             cmd,
	input  logic [iwt_pkg::VALUE_W-1:0]  value,
	output iwt_pkg::dp_stat_t            stat,
	output logic                         strobe,
	output logic [iwt_pkg::WORD_W-1:0]   word,
	output logic                         last
);

	logic [iwt_pkg::VALUE_W-1:0] bin_q;
	logic [iwt_pkg::BCD_W-1:0]   bcd_q;
	logic [iwt_pkg::BCD_W-1:0]   bcd_adj;
	logic [3:0]                  dig_h [iwt_pkg::GROUPS];
	logic [3:0]                  dig_t [iwt_pkg::GROUPS];
	logic [3:0]                  dig_o [iwt_pkg::GROUPS];
	logic [3:0]                  h;
	logic [3:0]                  t;
	logic [3:0]                  o;
	logic [iwt_pkg::WORD_W-1:0]  word_d;
	logic [iwt_pkg::WORD_W-1:0]  word_q;
	logic                        strobe_q;
	logic                        last_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < iwt_pkg::DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (cmd.shift) begin
			bin_q <= {bin_q[iwt_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[iwt_pkg::BCD_W-2:0], bin_q[iwt_pkg::VALUE_W-1]};
		end
	end

	// digits per group; the billion group has only a ones digit
	always_comb begin
		for (int g = 0; g < iwt_pkg::GROUPS - 1; g++) begin
			dig_o[g] = bcd_q[12*g +: 4];
			dig_t[g] = bcd_q[12*g + 4 +: 4];
			dig_h[g] = bcd_q[12*g + 8 +: 4];
		end
		dig_o[iwt_pkg::GROUPS-1] = bcd_q[iwt_pkg::BCD_W-1 -: 4];
		dig_t[iwt_pkg::GROUPS-1] = 4'd0;
		dig_h[iwt_pkg::GROUPS-1] = 4'd0;
		for (int g = 0; g < iwt_pkg::GROUPS; g++) begin
			stat.hund_nz[g] = (dig_h[g] != 4'd0);
			stat.tail_nz[g] = (dig_t[g] != 4'd0) || (dig_o[g] != 4'd0);
			stat.pair[g]    = (dig_t[g] >= 4'd2) && (dig_o[g] != 4'd0);
			stat.grp_nz[g]  = stat.hund_nz[g] || stat.tail_nz[g];
		end
	end

	assign h = dig_h[cmd.grp];
	assign t = dig_t[cmd.grp];
	assign o = dig_o[cmd.grp];

	always_comb begin
		unique case (cmd.sel)
			iwt_pkg::SEL_ZERO:  word_d = iwt_pkg::WORD_ZERO;
			iwt_pkg::SEL_HDIG:  word_d = {1'b0, h};
			iwt_pkg::SEL_HWORD: word_d = iwt_pkg::WORD_HUNDRED;
			iwt_pkg::SEL_TAIL: begin
				if (t >= 4'd2) begin
					word_d = iwt_pkg::WORD_TWENTY - 5'd2 + {1'b0, t};
				end else if (t[0]) begin
					word_d = iwt_pkg::WORD_TEN + {1'b0, o};
				end else begin
					word_d = {1'b0, o};
				end
			end
			iwt_pkg::SEL_ONES:  word_d = {1'b0, o};
			iwt_pkg::SEL_SCALE: word_d = iwt_pkg::WORD_HUNDRED
				+ {{(iwt_pkg::WORD_W-iwt_pkg::GRP_W){1'b0}}, cmd.grp};
			default:            word_d = iwt_pkg::WORD_ZERO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			last_q   <= cmd.emit && cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			word_q <= word_d;
		end
	end

	assign strobe = strobe_q;
	assign word   = word_q;
	assign last   = last_q;

	a_zero_is_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && $past(cmd.sel) == iwt_pkg::SEL_ZERO) |-> last_q)
		else $error("Zero word not marked last");

endmodule

FILE: rtl/iwt_ctrl.sv
// Controller: sequences conversion, group scan and word emission.
module iwt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  iwt_pkg::dp_stat_t stat,
	output iwt_pkg::dp_cmd_t  cmd,
	output logic              busy
);

	iwt_pkg::state_t             st_q, st_d, in_next, first_ph;
	logic [iwt_pkg::GRP_W-1:0]   grp_q, grp_d, low_g, top_g, nxt_g;
	logic                        has_low, has_top;
	logic [iwt_pkg::CNT_W-1:0]   cnt_q, cnt_d;

	// highest nonzero group below the current one, and highest overall;
	// the scan starts at the top group, a finished group drops to the lower one
	always_comb begin
		low_g   = '0;
		has_low = 1'b0;
		top_g   = '0;
		has_top = 1'b0;
		for (int i = 0; i < iwt_pkg::GROUPS; i++) begin
			if (stat.grp_nz[i] && (i < int'(grp_q))) begin
				low_g   = iwt_pkg::GRP_W'(i);
				has_low = 1'b1;
			end
			if (stat.grp_nz[i]) begin
				top_g   = iwt_pkg::GRP_W'(i);
				has_top = 1'b1;
			end
		end
		nxt_g = (st_q == iwt_pkg::ST_SCAN) ? top_g : low_g;
	end

	// first phase of the group that is about to start
	always_comb begin
		if (stat.hund_nz[nxt_g]) begin
			first_ph = iwt_pkg::ST_HDIG;
		end else if (stat.tail_nz[nxt_g]) begin
			first_ph = iwt_pkg::ST_TAIL;
		end else begin
			first_ph = iwt_pkg::ST_SCALE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= iwt_pkg::ST_IDLE;
			grp_q <= '0;
			cnt_q <= '0;
		end else begin
			st_q  <= st_d;
			grp_q <= grp_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		grp_d     = grp_q;
		cnt_d     = cnt_q;
		in_next   = iwt_pkg::ST_IDLE;
		cmd.load  = 1'b0;
		cmd.shift = 1'b0;
		cmd.emit  = 1'b0;
		cmd.last  = 1'b0;
		cmd.sel   = iwt_pkg::SEL_ZERO;
		cmd.grp   = grp_q;
		unique case (st_q)
			iwt_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					st_d     = iwt_pkg::ST_CONV;
				end
			end
			iwt_pkg::ST_CONV: begin
				cmd.shift = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == iwt_pkg::CNT_W'(iwt_pkg::VALUE_W - 1)) begin
					st_d = iwt_pkg::ST_SCAN;
				end
			end
			iwt_pkg::ST_SCAN: begin
				if (has_top) begin
					grp_d = top_g;
					st_d  = first_ph;
				end else begin
					st_d = iwt_pkg::ST_ZERO;
				end
			end
			iwt_pkg::ST_ZERO: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				cmd.sel  = iwt_pkg::SEL_ZERO;
				st_d     = iwt_pkg::ST_IDLE;
			end
			default: begin
				cmd.emit = 1'b1;
				priority case (st_q)
					iwt_pkg::ST_HDIG: begin
						cmd.sel = iwt_pkg::SEL_HDIG;
						in_next = iwt_pkg::ST_HWORD;
					end
					iwt_pkg::ST_HWORD: begin
						cmd.sel = iwt_pkg::SEL_HWORD;
						if (stat.tail_nz[grp_q]) begin
							in_next = iwt_pkg::ST_TAIL;
						end else if (grp_q != '0) begin
							in_next = iwt_pkg::ST_SCALE;
						end
					end
					iwt_pkg::ST_TAIL: begin
						cmd.sel = iwt_pkg::SEL_TAIL;
						if (stat.pair[grp_q]) begin
							in_next = iwt_pkg::ST_ONES;
						end else if (grp_q != '0) begin
							in_next = iwt_pkg::ST_SCALE;
						end
					end
					iwt_pkg::ST_ONES: begin
						cmd.sel = iwt_pkg::SEL_ONES;
						if (grp_q != '0) begin
							in_next = iwt_pkg::ST_SCALE;
						end
					end
					default: begin
						cmd.sel = iwt_pkg::SEL_SCALE;
					end
				endcase
				// group finished: move down to the next nonzero group or drop out
				if (in_next != iwt_pkg::ST_IDLE) begin
					st_d = in_next;
				end else if (has_low) begin
					grp_d = low_g;
					st_d  = first_ph;
				end else begin
					cmd.last = 1'b1;
					st_d     = iwt_pkg::ST_IDLE;
				end
			end
		endcase
	end

	assign busy = (st_q != iwt_pkg::ST_IDLE);

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == iwt_pkg::ST_IDLE && $past(st_q) != iwt_pkg::ST_IDLE) |-> $past(cmd.last))
		else $error("Run ended without a last word");

	a_last_is_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last |-> (cmd.emit && st_d == iwt_pkg::ST_IDLE))
		else $error("Last flag outside an emitted final word");

	a_group_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && $past(cmd.emit)) |-> (grp_q <= $past(grp_q)))
		else $error("Group order went upward within a run");

endmodule

FILE: rtl/integer_to_word_tokens.sv
// Top level: spells a 31-bit unsigned integer as a run of English word codes.
//
// Pulse start with value while busy is low to begin a transaction; busy goes
// high on the next cycle and stays high until the final word has been issued. The value
// is converted to ten decimal digits by a shift-and-add-3 converter that takes
// one input bit per cycle, the scan state then picks the leading nonzero
// three-digit group, and then one word code is issued per cycle: strobe is high
// for exactly one cycle per word with the code on word, and last marks the final
// word of the run. The receiver cannot stall this block, so every strobed word
// must be taken in that cycle. Words run from the billion group down to the
// units group; zero groups give nothing, and a value of zero gives the single
// word Zero. A run holds 1 to 16 words. Busy stays high from the accepting edge
// until the final word is issued, so a new value is taken only after the previous
// run; the final word's strobe is registered and shows in the same cycle that busy
// goes low. Most of the busy time goes to the bit-serial conversion.
module integer_to_word_tokens (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [iwt_pkg::VALUE_W-1:0] value,
	output logic                        strobe,
	output logic [iwt_pkg::WORD_W-1:0]  word,
	output logic                        last
);

	iwt_pkg::dp_cmd_t  cmd;
	iwt_pkg::dp_stat_t stat;

	// sequencer: conversion count, group walk, word phases
	iwt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// converter, digit flags and registered word output
	iwt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (value),
		.stat   (stat),
		.strobe (strobe),
		.word   (word),
		.last   (last)
	);

endmodule

FILE: test/iwt_word_checker.sv
// Checker for the integer-to-words block: predicts each run of word codes and compares.
`timescale 1ns / 100ps

module iwt_word_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [iwt_pkg::VALUE_W-1:0] value,
	input  logic                        strobe,
	input  logic [iwt_pkg::WORD_W-1:0]  word,
	input  logic                        last,
	output int                          mismatches,
	output int                          words_owed
);

	localparam logic [iwt_pkg::WORD_W-1:0] WORD_THOUSAND = 5'd29;
	localparam logic [iwt_pkg::WORD_W-1:0] WORD_MILLION  = 5'd30;
	localparam logic [iwt_pkg::WORD_W-1:0] WORD_BILLION  = 5'd31;

	typedef struct packed {
		logic [iwt_pkg::WORD_W-1:0] code;
		logic                       fin;
	} spoken_t;

	spoken_t expected_words[$];

	function automatic void say(logic [iwt_pkg::WORD_W-1:0] code);
		spoken_t tok;
		tok.code = code;
		tok.fin  = 1'b0;
		expected_words.push_back(tok);
	endfunction

	// One group 1..999, then its scale word when it has one.
	function automatic void say_group(int unsigned grp, logic [iwt_pkg::WORD_W-1:0] scale,
		bit scaled);
		int unsigned hund;
		int unsigned tail;
		int unsigned tens;
		int unsigned ones;
		hund = grp / 100;
		tail = grp % 100;
		tens = tail / 10;
		ones = tail % 10;
		if (hund != 0) begin
			say(iwt_pkg::WORD_W'(hund));
			say(iwt_pkg::WORD_HUNDRED);
		end
		if (tail > 20 && ones != 0) begin
			say(iwt_pkg::WORD_TWENTY + iwt_pkg::WORD_W'(tens - 2));
			say(iwt_pkg::WORD_W'(ones));
		end else if (tail != 0) begin
			if (tail <= 20)
				say(iwt_pkg::WORD_W'(tail));
			else
				say(iwt_pkg::WORD_TWENTY + iwt_pkg::WORD_W'(tens - 2));
		end
		if (scaled)
			say(scale);
	endfunction

	function automatic void spell_value(logic [iwt_pkg::VALUE_W-1:0] v);
		int unsigned n;
		spoken_t     final_tok;
		n = {1'b0, v};
		if (n == 0) begin
			say(iwt_pkg::WORD_ZERO);
		end else begin
			if ((n / 1000000000) != 0)
				say_group(n / 1000000000, WORD_BILLION, 1'b1);
			if (((n / 1000000) % 1000) != 0)
				say_group((n / 1000000) % 1000, WORD_MILLION, 1'b1);
			if (((n / 1000) % 1000) != 0)
				say_group((n / 1000) % 1000, WORD_THOUSAND, 1'b1);
			if ((n % 1000) != 0)
				say_group(n % 1000, iwt_pkg::WORD_ZERO, 1'b0);
		end
		final_tok = expected_words.pop_back();
		final_tok.fin = 1'b1;
		expected_words.push_back(final_tok);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spoken_t due;
		int      errs;
		if (!arst_n) begin
			expected_words.delete();
			mismatches <= 0;
			words_owed <= 0;
		end else begin
			errs = 0;
			if (strobe) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %0d (last %0b)", $time, word, last);
					errs++;
				end else begin
					due = expected_words.pop_front();
					if (word !== due.code) begin
						$display("%0t: word mismatch: expected %0d, got %0d",
							$time, due.code, word);
						errs++;
					end
					if (last !== due.fin) begin
						$display("%0t: last mismatch: expected %0b, got %0b",
							$time, due.fin, last);
						errs++;
					end
				end
			end
			if (start && !busy)
				spell_value(value);
			mismatches <= mismatches + errs;
			words_owed <= expected_words.size();
		end
	end

endmodule

FILE: test/tb.sv
// Testbench top: drives values into the integer-to-words block and reports the verdict.
`timescale 1ns / 100ps

module tb;

	// Quiet cycles allowed before the run is declared hung. This is many times
	// what one value and the short sender gaps take.
	localparam int QUIET_LIMIT = 600;
	localparam int PHASE_ITEMS = 72;

	logic                        clk;
	logic                        arst_n;
	logic                        start;
	logic                        busy;
	logic [iwt_pkg::VALUE_W-1:0] value;
	logic                        strobe;
	logic [iwt_pkg::WORD_W-1:0]  word;
	logic                        last;
	int                          mismatches;
	int                          words_owed;
	int                          quiet;

	// Directed values: extremes, every tail shape, every scale, the widest run.
	int unsigned corners[24] = '{
		0, 1, 9, 10, 11, 19, 20, 21, 30, 99, 100, 101, 110, 120, 999, 1000,
		1001, 1000000, 1000000000, 2147483647, 1073741824, 12345, 1100000011,
		2000020017
	};

	// Sender idle percentage per random phase; the receiver can't stall, so
	// the phases that would stall it reduce to their sender part.
	int idle_pct[4] = '{0, 70, 0, 14};

	integer_to_word_tokens dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.value  (value),
		.strobe (strobe),
		.word   (word),
		.last   (last)
	);

	iwt_word_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.strobe     (strobe),
		.word       (word),
		.last       (last),
		.mismatches (mismatches),
		.words_owed (words_owed)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Count cycles with neither an accepted transaction nor a word.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Pick a three-digit group, biased toward zero groups and short tails.
	function automatic int unsigned pick_group();
		case ($urandom_range(0, 6))
			0:       return 0;
			1:       return $urandom_range(1, 20);
			2:       return 10 * $urandom_range(1, 9);
			3:       return 100 * $urandom_range(1, 9) + $urandom_range(0, 20);
			4:       return 100 * $urandom_range(1, 9);
			default: return $urandom_range(0, 999);
		endcase
	endfunction

	function automatic logic [iwt_pkg::VALUE_W-1:0] pick_value();
		longint unsigned acc;
		case ($urandom_range(0, 9))
			0, 1: acc = $urandom & 32'h7FFF_FFFF;
			2:    acc = $urandom_range(0, 999);
			3:    acc = $urandom_range(0, 999999);
			default: begin
				acc = 64'd1_000_000_000 * $urandom_range(0, 2)
					+ 64'd1_000_000 * pick_group()
					+ 64'd1_000 * pick_group()
					+ pick_group();
				// Pull billion group 2 back into range where it overflows.
				if (acc > 64'd2147483647)
					acc = acc - 64'd1_000_000_000;
			end
		endcase
		return acc[iwt_pkg::VALUE_W-1:0];
	endfunction

	// Hold start with the value until the block takes it. Start stays high
	// afterward so a back-to-back value needs no second assignment.
	task automatic send_value(input logic [iwt_pkg::VALUE_W-1:0] v);
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// With the given probability, drop start, wait for the block to go idle,
	// then stay idle for a random number of further cycles.
	task automatic sender_gap(input int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			value <= iwt_pkg::VALUE_W'($urandom);
			do @(posedge clk); while (busy);
			while ($urandom_range(0, 99) < pct)
				@(posedge clk);
		end
	endtask

	// Hold off until every predicted word has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (words_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		value  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corners[i])
			send_value(corners[i][iwt_pkg::VALUE_W-1:0]);
		drain();

		foreach (idle_pct[p]) begin
			repeat (PHASE_ITEMS) begin
				sender_gap(idle_pct[p]);
				send_value(pick_value());
			end
			drain();
		end

		// Let any stray word show up before the verdict.
		repeat (60) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/iwt_pkg.sv
rtl/iwt_dp.sv
rtl/iwt_ctrl.sv
rtl/integer_to_word_tokens.sv
test/iwt_word_checker.sv
test/tb.sv
